// ----- hdl/sbb_pkg.sv -----
// sbb_pkg: shared types, constants and small helper functions for the box blur
// used by sbb_lane and separable_box_blur; depends on nothing
package sbb_pkg;

    localparam int MAX_RADIUS = 15;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int LANES      = 4;
    localparam int WINDOW     = 2 * MAX_RADIUS + 1;
    localparam int LS_DEPTH   = WINDOW * MAX_WIDTH;
    localparam int LS_AW      = $clog2(LS_DEPTH);
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ACC_W      = $clog2(WINDOW * 255 + 1);
    localparam int WEIGHT_W   = 17;
    localparam int PROD_W     = ACC_W + WEIGHT_W;
    localparam int FRAC_W     = 16;

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_WIDTH    = 2'd1;
    localparam logic [1:0] REG_HEIGHT   = 2'd2;
    localparam logic [1:0] REG_CHANNELS = 2'd3;

    typedef struct packed {
        logic       command;
        logic [7:0] sample_0;
        logic [7:0] sample_1;
        logic [7:0] sample_2;
        logic [7:0] sample_3;
    } pixel_t;

    typedef struct packed {
        logic [7:0] blurred_0;
        logic [7:0] blurred_1;
        logic [7:0] blurred_2;
        logic [7:0] blurred_3;
        logic       last_of_run;
        logic       frame_done;
    } result_t;

    typedef struct packed {
        logic clear;
        logic add;
        logic mul;
    } lane_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COL,
        S_HACC,
        S_HMUL,
        S_HWR,
        S_VRD,
        S_VWAIT,
        S_VMUL,
        S_VOUT,
        S_NEXT
    } state_t;

    // floor(65536 / (2r + 1))
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [3:0] r);
        logic [WEIGHT_W-1:0] w;
        unique case (r)
            4'd0:    w = 17'd65536;
            4'd1:    w = 17'd21845;
            4'd2:    w = 17'd13107;
            4'd3:    w = 17'd9362;
            4'd4:    w = 17'd7281;
            4'd5:    w = 17'd5957;
            4'd6:    w = 17'd5041;
            4'd7:    w = 17'd4369;
            4'd8:    w = 17'd3855;
            4'd9:    w = 17'd3449;
            4'd10:   w = 17'd3120;
            4'd11:   w = 17'd2849;
            4'd12:   w = 17'd2621;
            4'd13:   w = 17'd2427;
            4'd14:   w = 17'd2259;
            default: w = 17'd2114;
        endcase
        return w;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(WINDOW - 1)) ? '0 : s + 1'b1;
    endfunction

    // (s - d) mod window, d below the window size
    function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] s,
                                                  input logic [SLOT_W-1:0] d);
        logic [SLOT_W:0] t;
        t = {1'b0, s} + SLOT_W'(WINDOW) - {1'b0, d};
        if (s >= d)
            return s - d;
        return t[SLOT_W-1:0];
    endfunction

endpackage

// ----- hdl/sbb_lane.sv -----
// sbb_lane: one channel lane, tap accumulator and fixed-point scaler
// depends on sbb_pkg
module sbb_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbb_pkg::lane_ctl_t            ctl,
    input  logic                          enable,
    input  logic [7:0]                    sample,
    input  logic [sbb_pkg::WEIGHT_W-1:0]  weight,
    output logic [7:0]                    scaled
);

    logic [sbb_pkg::ACC_W-1:0]  acc_reg;
    logic [sbb_pkg::ACC_W-1:0]  acc_next;
    logic [sbb_pkg::PROD_W-1:0] prod_reg;
    logic [sbb_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        acc_next  = acc_reg;
        prod_next = prod_reg;
        if (ctl.clear)
            acc_next = '0;
        else if (ctl.add)
            acc_next = acc_reg + sbb_pkg::ACC_W'(sample);
        if (ctl.mul)
            prod_next = sbb_pkg::PROD_W'(acc_reg) * sbb_pkg::PROD_W'(weight);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // drop the fraction, saturate to a byte; zero for a disabled lane
    always_comb
    begin
        if (!enable)
            scaled = 8'd0;
        else if (prod_reg[sbb_pkg::PROD_W-1:sbb_pkg::FRAC_W+8] != '0)
            scaled = 8'd255;
        else
            scaled = prod_reg[sbb_pkg::FRAC_W +: 8];
    end

endmodule

// ----- hdl/separable_box_blur.sv -----
// separable_box_blur: top level, sequencer, row window, line store and lane merge
// depends on sbb_pkg and sbb_lane
//
//  channel  direction  handshake              payload
//  pix      in         pix_valid / pix_stall  pixel_t (command, sample_0..3)
//  res      out        res_valid / res_stall  result_t (blurred_0..3, flags)
//  cfg      in         cfg_write              cfg_index, cfg_data
//
// an item is taken in the idle state, then per computed column come a setup step, a
// horizontal pass for an image row (row window taps one per cycle), a vertical pass
// (one line store read port) and a step; a row end computes up to R+1 columns
// the line store has no reset; rows are always written before they are read
// pix_stall is high while an item is being worked; a stalled result holds the
// sequencer in its output step
module separable_box_blur (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  sbb_pkg::pixel_t     pix,
    output logic                res_valid,
    input  logic                res_stall,
    output sbb_pkg::result_t    res,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data
);

    localparam int SW = sbb_pkg::SLOT_W;
    localparam int CW = sbb_pkg::COL_W;

    sbb_pkg::state_t state_reg, state_next;

    logic [3:0]                   radius_reg, radius_next;
    logic [11:0]                  width_reg, width_next;
    logic [12:0]                  height_reg, height_next;
    logic [2:0]                   chans_reg, chans_next;
    logic [sbb_pkg::WEIGHT_W-1:0] weight_reg, weight_next;

    logic [CW-1:0] col_reg, col_next;
    logic [SW-1:0] col_slot_reg, col_slot_next;
    logic [12:0]   row_reg, row_next;
    logic [SW-1:0] row_slot_reg, row_slot_next;

    logic [12:0]   cur_row_reg, cur_row_next;
    logic [SW-1:0] cur_row_slot_reg, cur_row_slot_next;
    logic          do_h_reg, do_h_next;
    logic          do_v_reg, do_v_next;
    logic [CW-1:0] c_reg, c_next;
    logic [SW-1:0] c_slot_reg, c_slot_next;
    logic [CW-1:0] last_c_reg, last_c_next;

    logic signed [13:0] tap_p_reg, tap_p_next;
    logic [SW-1:0]      tap_s_reg, tap_s_next;
    logic [SW-1:0]      tap_cnt_reg, tap_cnt_next;
    logic               rd_pend_reg, rd_pend_next;

    logic              res_valid_reg, res_valid_next;
    sbb_pkg::result_t  res_reg, res_next;

    logic [31:0] row_window [sbb_pkg::WINDOW];
    logic [31:0] ls_mem [sbb_pkg::LS_DEPTH];
    logic [31:0] ls_rdata_reg;
    logic                  ls_we;
    logic [sbb_pkg::LS_AW-1:0] ls_waddr;
    logic [sbb_pkg::LS_AW-1:0] ls_raddr;

    logic [11:0]   eff_w;
    logic [CW-1:0] wm1;
    logic [12:0]   eff_h;
    logic [11:0]   hm1;
    logic [2:0]    eff_lanes;
    logic [sbb_pkg::LANES-1:0] lane_en;

    logic          pix_acc;
    logic          image_row;
    logic          cmd_ok;
    logic          row_end;
    logic          col_ge_r;
    logic [31:0]   px_word;
    logic [13:0]   row_plus;

    logic signed [13:0] p0h, p0v, pn, hi;
    logic [SW-1:0]      s0h, s0v, s_step;
    logic [SW-1:0]      two_r;

    sbb_pkg::lane_ctl_t lane_ctl;
    logic [7:0]         lane_in  [sbb_pkg::LANES];
    logic [7:0]         lane_out [sbb_pkg::LANES];
    logic [31:0]        merged;

    // effective register values
    always_comb
    begin
        if (width_reg == 12'd0)
            eff_w = 12'd1;
        else if (width_reg > 12'(sbb_pkg::MAX_WIDTH))
            eff_w = 12'(sbb_pkg::MAX_WIDTH);
        else
            eff_w = width_reg;
        if (height_reg == 13'd0)
            eff_h = 13'd1;
        else if (height_reg > 13'(sbb_pkg::MAX_HEIGHT))
            eff_h = 13'(sbb_pkg::MAX_HEIGHT);
        else
            eff_h = height_reg;
        if (chans_reg == 3'd0)
            eff_lanes = 3'd1;
        else if (chans_reg > 3'(sbb_pkg::LANES))
            eff_lanes = 3'(sbb_pkg::LANES);
        else
            eff_lanes = chans_reg;
    end

    assign wm1 = CW'(eff_w - 12'd1);
    assign hm1 = 12'(eff_h - 13'd1);
    assign two_r = {radius_reg, 1'b0};

    for (genvar i = 0; i < sbb_pkg::LANES; i++)
    begin : g_en
        assign lane_en[i] = (3'(i) < eff_lanes);
    end

    assign pix_acc   = pix_valid && (state_reg == sbb_pkg::S_IDLE);
    assign pix_stall = (state_reg != sbb_pkg::S_IDLE);
    assign image_row = (row_reg < eff_h);
    assign cmd_ok    = (pix.command == !image_row);
    assign row_end   = (col_reg == wm1);
    assign col_ge_r  = (col_reg >= CW'(radius_reg));
    assign row_plus  = {1'b0, row_reg} + 14'd1;

    assign px_word = {(lane_en[3] ? pix.sample_3 : 8'd0), (lane_en[2] ? pix.sample_2 : 8'd0),
                      (lane_en[1] ? pix.sample_1 : 8'd0), (lane_en[0] ? pix.sample_0 : 8'd0)};

    // tap walk with clamping at both ends
    assign p0h = $signed({3'b0, c_reg}) - $signed({10'b0, radius_reg});
    assign s0h = p0h[13] ? '0 : sbb_pkg::slot_sub(c_slot_reg, SW'(radius_reg));
    assign p0v = $signed({1'b0, cur_row_reg}) - $signed({9'b0, two_r});
    assign s0v = p0v[13] ? '0 : sbb_pkg::slot_sub(cur_row_slot_reg, two_r);
    assign pn  = tap_p_reg + 14'sd1;
    assign hi  = (state_reg == sbb_pkg::S_HACC) ? $signed({3'b0, wm1}) : $signed({2'b0, hm1});

    always_comb
    begin
        if (pn <= 14'sd0)
            s_step = '0;
        else if (pn > hi)
            s_step = tap_s_reg;
        else
            s_step = sbb_pkg::slot_inc(tap_s_reg);
    end

    // lanes and merge
    always_comb
    begin
        lane_ctl.clear = (state_reg == sbb_pkg::S_COL) || (state_reg == sbb_pkg::S_HWR);
        lane_ctl.add   = (state_reg == sbb_pkg::S_HACC) || rd_pend_reg;
        lane_ctl.mul   = (state_reg == sbb_pkg::S_HMUL) || (state_reg == sbb_pkg::S_VMUL);
    end

    for (genvar i = 0; i < sbb_pkg::LANES; i++)
    begin : g_lane
        assign lane_in[i] = (state_reg == sbb_pkg::S_HACC) ? row_window[tap_s_reg][8*i +: 8]
                                                           : ls_rdata_reg[8*i +: 8];
        sbb_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lane_ctl),
            .enable (lane_en[i]),
            .sample (lane_in[i]),
            .weight (weight_reg),
            .scaled (lane_out[i])
        );
        assign merged[8*i +: 8] = lane_out[i];
    end

    // line store
    assign ls_we    = (state_reg == sbb_pkg::S_HWR);
    assign ls_waddr = sbb_pkg::LS_AW'(cur_row_slot_reg) * sbb_pkg::LS_AW'(sbb_pkg::MAX_WIDTH)
                    + sbb_pkg::LS_AW'(c_reg);
    assign ls_raddr = sbb_pkg::LS_AW'(tap_s_reg) * sbb_pkg::LS_AW'(sbb_pkg::MAX_WIDTH)
                    + sbb_pkg::LS_AW'(c_reg);

    always_ff @(posedge clk)
    begin
        if (ls_we)
            ls_mem[ls_waddr] <= merged;
        ls_rdata_reg <= ls_mem[ls_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sbb_pkg::WINDOW; i++)
                row_window[i] <= '0;
        end
        else if (pix_acc && cmd_ok && image_row)
        begin
            row_window[col_slot_reg] <= px_word;
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        radius_next       = radius_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        chans_next        = chans_reg;
        weight_next       = weight_reg;
        col_next          = col_reg;
        col_slot_next     = col_slot_reg;
        row_next          = row_reg;
        row_slot_next     = row_slot_reg;
        cur_row_next      = cur_row_reg;
        cur_row_slot_next = cur_row_slot_reg;
        do_h_next         = do_h_reg;
        do_v_next         = do_v_reg;
        c_next            = c_reg;
        c_slot_next       = c_slot_reg;
        last_c_next       = last_c_reg;
        tap_p_next        = tap_p_reg;
        tap_s_next        = tap_s_reg;
        tap_cnt_next      = tap_cnt_reg;
        rd_pend_next      = 1'b0;
        res_next          = res_reg;
        res_valid_next    = res_valid_reg && res_stall;

        unique case (state_reg)
            sbb_pkg::S_IDLE:
            begin
                if (pix_acc && cmd_ok)
                begin
                    cur_row_next      = row_reg;
                    cur_row_slot_next = row_slot_reg;
                    do_h_next         = image_row;
                    do_v_next         = (row_reg >= 13'(radius_reg));
                    c_next            = col_ge_r ? col_reg - CW'(radius_reg) : '0;
                    c_slot_next       = col_ge_r ? sbb_pkg::slot_sub(col_slot_reg, SW'(radius_reg))
                                                 : '0;
                    last_c_next       = row_end ? col_reg : c_next;
                    if ((row_end || col_ge_r) && (image_row || (row_reg >= 13'(radius_reg))))
                        state_next = sbb_pkg::S_COL;
                    if (row_end)
                    begin
                        col_next      = '0;
                        col_slot_next = '0;
                        row_next      = row_plus[12:0];
                        row_slot_next = sbb_pkg::slot_inc(row_slot_reg);
                        if (row_plus >= {1'b0, eff_h} + 14'(radius_reg))
                        begin
                            row_next      = '0;
                            row_slot_next = '0;
                        end
                    end
                    else
                    begin
                        col_next      = col_reg + 1'b1;
                        col_slot_next = sbb_pkg::slot_inc(col_slot_reg);
                    end
                end
            end
            sbb_pkg::S_COL:
            begin
                tap_cnt_next = '0;
                if (do_h_reg)
                begin
                    tap_p_next = p0h;
                    tap_s_next = s0h;
                    state_next = sbb_pkg::S_HACC;
                end
                else
                begin
                    tap_p_next = p0v;
                    tap_s_next = s0v;
                    state_next = sbb_pkg::S_VRD;
                end
            end
            sbb_pkg::S_HACC:
            begin
                tap_p_next   = pn;
                tap_s_next   = s_step;
                tap_cnt_next = tap_cnt_reg + 1'b1;
                if (tap_cnt_reg == two_r)
                    state_next = sbb_pkg::S_HMUL;
            end
            sbb_pkg::S_HMUL:
            begin
                state_next = sbb_pkg::S_HWR;
            end
            sbb_pkg::S_HWR:
            begin
                tap_cnt_next = '0;
                tap_p_next   = p0v;
                tap_s_next   = s0v;
                state_next   = do_v_reg ? sbb_pkg::S_VRD : sbb_pkg::S_NEXT;
            end
            sbb_pkg::S_VRD:
            begin
                rd_pend_next = 1'b1;
                tap_p_next   = pn;
                tap_s_next   = s_step;
                tap_cnt_next = tap_cnt_reg + 1'b1;
                if (tap_cnt_reg == two_r)
                    state_next = sbb_pkg::S_VWAIT;
            end
            sbb_pkg::S_VWAIT:
            begin
                state_next = sbb_pkg::S_VMUL;
            end
            sbb_pkg::S_VMUL:
            begin
                state_next = sbb_pkg::S_VOUT;
            end
            sbb_pkg::S_VOUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next       = 1'b1;
                    res_next.blurred_0   = lane_out[0];
                    res_next.blurred_1   = lane_out[1];
                    res_next.blurred_2   = lane_out[2];
                    res_next.blurred_3   = lane_out[3];
                    res_next.last_of_run = (c_reg == last_c_reg);
                    res_next.frame_done  = (cur_row_reg == 13'(hm1) + 13'(radius_reg))
                                        && (c_reg == wm1);
                    state_next           = sbb_pkg::S_NEXT;
                end
            end
            sbb_pkg::S_NEXT:
            begin
                if (c_reg == last_c_reg)
                    state_next = sbb_pkg::S_IDLE;
                else
                begin
                    c_next      = c_reg + 1'b1;
                    c_slot_next = sbb_pkg::slot_inc(c_slot_reg);
                    state_next  = sbb_pkg::S_COL;
                end
            end
            default:
            begin
                state_next = sbb_pkg::S_IDLE;
            end
        endcase

        // any register write restarts the image
        if (cfg_write)
        begin
            unique case (cfg_index)
                sbb_pkg::REG_RADIUS:   radius_next = cfg_data[3:0];
                sbb_pkg::REG_WIDTH:    width_next  = cfg_data[11:0];
                sbb_pkg::REG_HEIGHT:   height_next = cfg_data[12:0];
                sbb_pkg::REG_CHANNELS: chans_next  = cfg_data[2:0];
                default:               chans_next  = chans_reg;
            endcase
            weight_next   = sbb_pkg::weight_of(radius_next);
            col_next      = '0;
            col_slot_next = '0;
            row_next      = '0;
            row_slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbb_pkg::S_IDLE;
            radius_reg    <= 4'd1;
            width_reg     <= 12'd640;
            height_reg    <= 13'd480;
            chans_reg     <= 3'd3;
            weight_reg    <= sbb_pkg::weight_of(4'd1);
            col_reg       <= '0;
            col_slot_reg  <= '0;
            row_reg       <= '0;
            row_slot_reg  <= '0;
            tap_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radius_reg    <= radius_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            chans_reg     <= chans_next;
            weight_reg    <= weight_next;
            col_reg       <= col_next;
            col_slot_reg  <= col_slot_next;
            row_reg       <= row_next;
            row_slot_reg  <= row_slot_next;
            tap_cnt_reg   <= tap_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg      <= cur_row_next;
        cur_row_slot_reg <= cur_row_slot_next;
        do_h_reg         <= do_h_next;
        do_v_reg         <= do_v_next;
        c_reg            <= c_next;
        c_slot_reg       <= c_slot_next;
        last_c_reg       <= last_c_next;
        tap_p_reg        <= tap_p_next;
        tap_s_reg        <= tap_s_next;
        res_reg          <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef ASSERT_OFF
    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbb_pkg::S_HACC || state_reg == sbb_pkg::S_VRD) |-> tap_cnt_reg <= two_r)
        else $error("tap count past kernel span");

    a_rd_pend: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(state_reg == sbb_pkg::S_VRD))
        else $error("line store data without a read");

    a_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (row_slot_reg < SW'(sbb_pkg::WINDOW)) && (col_slot_reg < SW'(sbb_pkg::WINDOW)))
        else $error("slot outside window");

    a_wr_col: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbb_pkg::S_HWR) |-> (c_reg <= wm1) && do_h_reg)
        else $error("line store write outside the row");
`endif

endmodule
